// ===== hdl/f8cv_pkg.sv =====
// Shared kinds, constants and pipeline types for the fp8/float32 converter.
package f8cv_pkg;

    typedef enum logic [2:0] {
        KIND_TO_E4M3     = 3'd0,
        KIND_TO_E4M3_SAT = 3'd1,
        KIND_TO_E5M2     = 3'd2,
        KIND_TO_E5M2_SAT = 3'd3,
        KIND_FROM_E4M3   = 3'd4,
        KIND_FROM_E5M2   = 3'd5
    } kind_t;

    localparam logic [31:0] F32_INF      = 32'h7f80_0000;
    localparam logic [31:0] F32_QNAN     = 32'hffc0_0000;
    localparam logic [31:0] E4M3_OVF_ABS = 32'h43e8_0000;
    localparam logic [31:0] E4M3_SAT_ABS = 32'h43e0_0000;
    localparam logic [31:0] E5M2_OVF_ABS = 32'h4770_0000;
    localparam logic [31:0] E5M2_SAT_ABS = 32'h4760_0000;
    localparam logic [7:0]  E4M3_NAN     = 8'hff;
    localparam logic [7:0]  E4M3_MAXF    = 8'h7e;
    localparam logic [7:0]  E5M2_QNAN_BYTE = 8'hfe;
    localparam logic [7:0]  E5M2_MAXF    = 8'h7b;
    localparam logic [7:0]  E5M2_INFV    = 8'h7c;

    // Special outcome of the encoder, settled in the first stage
    typedef enum logic [1:0] {
        ENC_NORMAL = 2'd0,
        ENC_FIXED  = 2'd1,
        ENC_ZERO   = 2'd2
    } enc_sel_t;

    // Encoder state after stage 1: shifted significand ready to round
    typedef struct packed {
        logic       valid;
        logic       is_enc;
        logic       is_e5;
        logic       sign;
        enc_sel_t   sel;
        logic [7:0] fixed;
        logic [4:0] ef;
        logic [3:0] off;
        logic [23:0] sig;
        logic [22:0] low;
        logic [31:0] dec;
    } stage1_t;

    // Encoder state after stage 2: kept bits and round decision
    typedef struct packed {
        logic       valid;
        logic       is_enc;
        logic       is_e5;
        logic       sign;
        enc_sel_t   sel;
        logic [7:0] fixed;
        logic [4:0] ef;
        logic [4:0] keep;
        logic       inc_lsb;
        logic [31:0] dec;
    } stage2_t;

endpackage

// ===== hdl/fp8_float32_converter.sv =====
// Top level of the fp8 E4M3FN/E5M2 to and from float32 converter.
// Pipeline: 3 register stages; the result waits in the last stage until taken.
// Throughput: one request per cycle while the output is free or being taken;
// the three register stages (classify and align, round decision, exponent
// add) all advance together on a free output and hold together on a stall.
// Reset: rst_n asynchronously clears all pipeline registers and valid bits.
module fp8_float32_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [31:0] float_in,
    input  logic [7:0]  fp8_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  fp8_out,
    output logic [31:0] float_out
);
    import f8cv_pkg::*;

    logic advance;

    // Move the whole pipe when the output slot is empty or being taken
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    f8cv_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .kind      (kind),
        .float_in  (float_in),
        .fp8_in    (fp8_in),
        .res_valid (out_valid),
        .res_fp8   (fp8_out),
        .res_float (float_out)
    );

    // A blocked result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fp8_out) && $stable(float_out))
        else $error("result dropped while stalled");
    // Ready only drops while the result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free output");
    // Offered results are fully known
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({fp8_out, float_out}))
        else $error("result has unknown bits");
endmodule

// ===== hdl/f8cv_pipe.sv =====
// Three-stage datapath of the converter with stall-aware valid bits.
module f8cv_pipe (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [2:0]  kind,
    input  logic [31:0] float_in,
    input  logic [7:0]  fp8_in,
    output logic        res_valid,
    output logic [7:0]  res_fp8,
    output logic [31:0] res_float
);
    import f8cv_pkg::*;

    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    logic        s3_valid_reg;
    logic [7:0]  s3_fp8_reg, s3_fp8_next;
    logic [31:0] s3_float_reg;

    // Stage 1: classify, decode fully, align encoder significand
    always_comb
    begin
        logic [31:0] a;
        logic        nan, e5, sat;
        logic signed [9:0] e;
        logic [3:0]  mb;
        logic [7:0]  s8;
        logic [4:0]  de;
        logic [2:0]  dm;
        logic [31:0] dv;
        logic [23:0] full;
        logic [3:0]  off;
        a    = {1'b0, float_in[30:0]};
        nan  = a > F32_INF;
        e5   = (kind == KIND_TO_E5M2) || (kind == KIND_TO_E5M2_SAT);
        sat  = (kind == KIND_TO_E4M3_SAT) || (kind == KIND_TO_E5M2_SAT);
        mb   = e5 ? 4'd2 : 4'd3;
        e    = $signed({2'b00, float_in[30:23]}) - 10'sd127 + (e5 ? 10'sd15 : 10'sd7);
        s8   = {float_in[31], 7'd0};
        s1_next = '0;
        s1_next.valid  = in_valid;
        s1_next.is_enc = (kind == KIND_TO_E4M3) || (kind == KIND_TO_E4M3_SAT) || e5;
        s1_next.is_e5  = e5;
        s1_next.sign   = float_in[31];
        s1_next.sel    = ENC_NORMAL;
        if (nan)
        begin
            s1_next.sel = ENC_FIXED;
            s1_next.fixed = e5 ? E5M2_QNAN_BYTE : E4M3_NAN;
        end
        else if (sat && a > (e5 ? E5M2_SAT_ABS : E4M3_SAT_ABS))
        begin
            s1_next.sel = ENC_FIXED;
            s1_next.fixed = s8 | (e5 ? E5M2_MAXF : E4M3_MAXF);
        end
        else if (!e5 && a > E4M3_OVF_ABS)
        begin
            s1_next.sel = ENC_FIXED;
            s1_next.fixed = E4M3_NAN;
        end
        else if (e5 && a >= E5M2_OVF_ABS)
        begin
            s1_next.sel = ENC_FIXED;
            s1_next.fixed = s8 | E5M2_INFV;
        end
        else if (e < -$signed({6'd0, mb}))
            s1_next.sel = ENC_ZERO;
        // Subnormal results shift the hidden bit in; off is at most 4 unless flushed to zero
        full = {1'b0, float_in[22:0]};
        off  = 4'd0;
        if (e <= 10'sd0)
        begin
            off  = 4'(10'sd1 - e);
            full = {1'b1, float_in[22:0]} >> off;
            s1_next.ef = 5'd0;
        end
        else
            s1_next.ef = e[4:0];
        s1_next.off = off;
        s1_next.sig = full;
        s1_next.low = float_in[22:0];
        // Decoder: exact and narrow, done here in full
        dv = '0;
        de = '0;
        dm = '0;
        if (kind == KIND_FROM_E4M3)
        begin
            de = {1'b0, fp8_in[6:3]};
            dm = fp8_in[2:0];
            if (fp8_in[6:0] == 7'h7f)
                dv = F32_QNAN;
            else if (de != 0)
                dv = {fp8_in[7], 8'(de + 8'd120), dm, 20'd0};
            else if (dm[2])
                dv = {fp8_in[7], 8'd120, dm[1:0], 21'd0};
            else if (dm[1])
                dv = {fp8_in[7], 8'd119, dm[0], 22'd0};
            else if (dm[0])
                dv = {fp8_in[7], 8'd118, 23'd0};
            else
                dv = {fp8_in[7], 31'd0};
        end
        else if (kind == KIND_FROM_E5M2)
        begin
            de = fp8_in[6:2];
            dm = {1'b0, fp8_in[1:0]};
            if (de == 5'h1f)
                dv = (dm != 0) ? F32_QNAN : {fp8_in[7], 31'h7f80_0000};
            else if (de != 0)
                dv = {fp8_in[7], 8'(de + 8'd112), dm[1:0], 21'd0};
            else if (dm[1])
                dv = {fp8_in[7], 8'd112, dm[0], 22'd0};
            else if (dm[0])
                dv = {fp8_in[7], 8'd111, 23'd0};
            else
                dv = {fp8_in[7], 31'd0};
        end
        s1_next.dec = dv;
    end

    // Stage 2: pick kept bits, guard and sticky, decide rounding
    always_comb
    begin
        logic [4:0]  keep;
        logic        guard, rest, sticky;
        logic [22:0] mask;
        mask   = (23'd1 << s1_reg.off) - 23'd1;
        sticky = |(s1_reg.low & mask);
        if (s1_reg.is_e5)
        begin
            keep  = {2'b00, s1_reg.sig[23:21]};
            guard = s1_reg.sig[20];
            rest  = |s1_reg.sig[19:0];
        end
        else
        begin
            keep  = {1'b0, s1_reg.sig[23:20]};
            guard = s1_reg.sig[19];
            rest  = |s1_reg.sig[18:0];
        end
        s2_next.valid    = s1_reg.valid;
        s2_next.is_enc   = s1_reg.is_enc;
        s2_next.is_e5    = s1_reg.is_e5;
        s2_next.sign     = s1_reg.sign;
        s2_next.sel      = s1_reg.sel;
        s2_next.fixed    = s1_reg.fixed;
        s2_next.ef       = s1_reg.ef;
        s2_next.keep     = keep;
        s2_next.inc_lsb  = guard && (rest || sticky || keep[0]);
        s2_next.dec      = s1_reg.dec;
    end

    // Stage 3: add exponent and rounded mantissa, let carry ripple up, or take the fixed or zero byte
    always_comb
    begin
        logic [7:0] mag;
        if (s2_reg.is_e5)
            mag = 8'({s2_reg.ef, 2'b00}) + 8'(s2_reg.keep) + 8'(s2_reg.inc_lsb);
        else
            mag = 8'({s2_reg.ef, 3'b000}) + 8'(s2_reg.keep) + 8'(s2_reg.inc_lsb);
        case (s2_reg.sel)
            ENC_FIXED: s3_fp8_next = s2_reg.fixed;
            ENC_ZERO:  s3_fp8_next = {s2_reg.sign, 7'd0};
            default:   s3_fp8_next = {s2_reg.sign, mag[6:0]};
        endcase
        if (!s2_reg.is_enc)
            s3_fp8_next = '0;
    end

    // Advance every stage on a free slot, hold on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_valid_reg <= 1'b0;
            s3_fp8_reg   <= '0;
            s3_float_reg <= '0;
        end
        else if (advance)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_valid_reg <= s2_reg.valid;
            s3_fp8_reg   <= s3_fp8_next;
            s3_float_reg <= s2_reg.dec;
        end
    end

    assign res_valid = s3_valid_reg;
    assign res_fp8   = s3_fp8_reg;
    assign res_float = s3_float_reg;

    // Stall keeps the last stage intact
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s3_valid_reg) && $stable(s3_fp8_reg))
        else $error("output stage changed during stall");
    // Valid moves one stage per advance
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> s3_valid_reg == $past(s2_reg.valid))
        else $error("valid bit lost between stages");
    // Decode results never carry an fp8 value
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_float_reg != 32'd0 |-> s3_fp8_reg == 8'd0)
        else $error("both result fields nonzero");
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the fp8 E4M3FN/E5M2 to and from float32 converter.
module tb_top;
    import f8cv_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  fp8;
        logic [31:0] f32;
    } conv_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [31:0] float_in;
    logic [7:0]  fp8_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  fp8_out;
    logic [31:0] float_out;

    conv_result_t pending_conv[$];
    int  mismatches = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  stalled_cycles = 0;
    bit  hold_on = 0;

    fp8_float32_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .float_in  (float_in),
        .fp8_in    (fp8_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fp8_out   (fp8_out),
        .float_out (float_out)
    );

    // Free-running clock, period 12
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Round a finite in-range float32 to an 8-bit magnitude, nearest even
    function automatic logic [7:0] round_to_fp8(logic [31:0] f, int mb, int bias);
        int          e;
        int          drop;
        int          off;
        logic [31:0] m;
        logic [31:0] sticky;
        logic [31:0] ef;
        logic [31:0] keep;
        logic [31:0] rest;
        logic        guard;
        e = int'(f[30:23]) - 127 + bias;
        m = {9'd0, f[22:0]};
        sticky = 0;
        ef = 0;
        drop = 23 - mb;
        if (e < -mb)
            return 8'd0;
        if (e <= 0)
        begin
            off = 1 - e;
            sticky = m & ((32'd1 << off) - 1);
            m = (m | 32'h0080_0000) >> off;
        end
        else
            ef = e;
        keep = m >> drop;
        guard = m[drop - 1];
        rest = m & ((32'd1 << (drop - 1)) - 1);
        if (guard && (rest != 0 || sticky != 0 || keep[0]))
            keep = keep + 1;
        return 8'((ef << mb) + keep);
    endfunction

    function automatic logic [7:0] encode_e4m3(logic [31:0] f, bit sat);
        logic [31:0] a;
        logic [7:0]  s;
        a = f & 32'h7fff_ffff;
        s = {f[31], 7'd0};
        if (a > F32_INF)
            return E4M3_NAN;
        if (sat && a > E4M3_SAT_ABS)
            return s | E4M3_MAXF;
        if (a > E4M3_OVF_ABS)
            return E4M3_NAN;
        return s | round_to_fp8(f, 3, 7);
    endfunction

    function automatic logic [7:0] encode_e5m2(logic [31:0] f, bit sat);
        logic [31:0] a;
        logic [7:0]  s;
        a = f & 32'h7fff_ffff;
        s = {f[31], 7'd0};
        if (a > F32_INF)
            return E5M2_QNAN_BYTE;
        if (sat && a > E5M2_SAT_ABS)
            return s | E5M2_MAXF;
        if (a >= E5M2_OVF_ABS)
            return s | E5M2_INFV;
        return s | round_to_fp8(f, 2, 15);
    endfunction

    // Exact widening of a finite 8-bit value; subnormals get normalized
    function automatic logic [31:0] widen_finite(logic [31:0] e, logic [31:0] m,
                                                 int mb, int bias);
        int p;
        p = 0;
        if (e == 0 && m == 0)
            return 32'd0;
        if (e != 0)
            return ((e + 127 - bias) << 23) | (m << (23 - mb));
        while (p + 1 < mb && (m >> (p + 1)) != 0)
            p++;
        return ((128 + p - bias - mb) << 23) | ((m - (32'd1 << p)) << (23 - p));
    endfunction

    function automatic conv_result_t predict_conv(logic [2:0] k, logic [31:0] f,
                                                  logic [7:0] b);
        conv_result_t r;
        r.kind = k;
        r.fp8 = 8'd0;
        r.f32 = 32'd0;
        case (k)
            KIND_TO_E4M3:     r.fp8 = encode_e4m3(f, 1'b0);
            KIND_TO_E4M3_SAT: r.fp8 = encode_e4m3(f, 1'b1);
            KIND_TO_E5M2:     r.fp8 = encode_e5m2(f, 1'b0);
            KIND_TO_E5M2_SAT: r.fp8 = encode_e5m2(f, 1'b1);
            KIND_FROM_E4M3:
                if (b[6:0] == 7'h7f)
                    r.f32 = F32_QNAN;
                else
                    r.f32 = {b[7], 31'd0} |
                            widen_finite(32'(b[6:3]), 32'(b[2:0]), 3, 7);
            KIND_FROM_E5M2:
                if (b[6:2] == 5'h1f)
                    r.f32 = (b[1:0] != 0) ? F32_QNAN : ({b[7], 31'd0} | F32_INF);
                else
                    r.f32 = {b[7], 31'd0} |
                            widen_finite(32'(b[6:2]), 32'(b[1:0]), 2, 15);
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %0s at %0t: got %h want %h", what, $time, got, want);
        mismatches++;
    endtask

    // Offer one request, hold it until taken, then idle at random
    task automatic send_item(logic [2:0] k, logic [31:0] f, logic [7:0] b);
        bit taken;
        in_valid <= 1'b1;
        kind     <= k;
        float_in <= f;
        fp8_in   <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_conv.push_back(predict_conv(k, f, b));
        sent_count++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Float32 pattern weighted toward the range of the 8-bit formats
    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(7))
            0, 1, 2, 3: f[30:23] = 8'($urandom_range(100, 145));
            4: f[30:23] = 8'($urandom_range(1) ? 8'hff : 8'h00);
            5: f[22:0] = {f[22:19], 19'h40000 | (f[18:0] & 19'h1)};
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_random(int count);
        logic [2:0] k;
        repeat (count)
        begin
            k = 3'($urandom_range(5));
            if ($urandom_range(49) == 0)
                k = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
            send_item(k, pick_float(), 8'($urandom));
        end
    endtask

    task automatic test_directed();
        logic [31:0] edge_vals[] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
            32'h43e8_0000, 32'h43e8_0001, 32'hc3e0_0001, 32'h43e0_0000,
            32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0001, 32'hffff_ffff,
            32'h4770_0000, 32'hc760_0001, 32'h3c7f_ffff, 32'h387f_ffff,
            32'h3b00_0000, 32'h3780_0000};
        logic [7:0] byte_vals[] = '{8'h00, 8'h80, 8'h01, 8'h7f, 8'hff, 8'h7c,
            8'hfc, 8'h7d, 8'h7e, 8'h07};
        foreach (edge_vals[i])
            send_item(3'(i % 4), edge_vals[i], 8'h00);
        foreach (byte_vals[i])
            send_item(i % 2 ? KIND_FROM_E5M2 : KIND_FROM_E4M3, 32'h0, byte_vals[i]);
        send_item(KIND_SPARE_6, 32'hffff_ffff, 8'hff);
        send_item(KIND_SPARE_7, 32'h3f80_0000, 8'h38);
    endtask

    // Decode a spread of byte patterns, alternating the two formats
    task automatic test_all_bytes();
        for (int b = 0; b < 256; b += 3)
            send_item(b[0] ? KIND_FROM_E5M2 : KIND_FROM_E4M3, 32'h0, 8'(b));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(count);
    endtask

    // Hold the output off while requests keep coming
    task automatic test_backpressure();
        fork
        begin
            hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_on = 1'b0;
        end
        join_none
        send_idle_pct = 0;
        send_random(60);
    endtask

    // Drive the output handshake
    always @(posedge clk)
        out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);

    // Check each result taken at the next edge and watch for a hang
    always @(negedge clk)
    begin
        conv_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_conv.size() == 0)
                report_mismatch("unexpected result", {24'd0, fp8_out}, float_out);
            else
            begin
                want = pending_conv.pop_front();
                if (fp8_out !== want.fp8)
                    report_mismatch($sformatf("fp8_out kind %0d", want.kind),
                                    {24'd0, fp8_out}, {24'd0, want.fp8});
                if (float_out !== want.f32)
                    report_mismatch($sformatf("float_out kind %0d", want.kind),
                                    float_out, want.f32);
                checked_count++;
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_TO_E4M3;
        float_in = 32'd0;
        fp8_in = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_all_bytes();
        test_random_phase(0, 0, 300);
        test_random_phase(49, 0, 300);
        test_random_phase(0, 49, 300);
        test_random_phase(14, 14, 300);
        test_backpressure();
        test_random_phase(0, 0, 100);
        in_valid <= 1'b0;
        while (pending_conv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests and %0d results: special values, all kinds,",
                 sent_count, checked_count);
        $display("random idling on both sides and a long output hold-off");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/f8cv_pkg.sv
hdl/f8cv_pipe.sv
hdl/fp8_float32_converter.sv
bench/tb_top.sv
